// ----- rtl/kdlp_pkg.sv -----
package kdlp_pkg;

  // Field widths
  localparam int unsigned KEY_BITS   = 4;
  localparam int unsigned THR_BITS   = 8;
  localparam int unsigned HOLD_BITS  = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_RESET_CODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLUS_CODE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MINUS_CODE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CONTROL_CODE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_THRESHOLD = 3'd4;

  // Register reset values
  localparam logic [KEY_BITS-1:0] RESET_CODE_DEFAULT   = 4'h1;
  localparam logic [KEY_BITS-1:0] PLUS_CODE_DEFAULT    = 4'h2;
  localparam logic [KEY_BITS-1:0] MINUS_CODE_DEFAULT   = 4'h4;
  localparam logic [KEY_BITS-1:0] CONTROL_CODE_DEFAULT = 4'h8;
  localparam logic [THR_BITS-1:0] LONG_THRESHOLD_DEFAULT = 8'd200;

  localparam logic [HOLD_BITS-1:0] HOLD_MAX = {HOLD_BITS{1'b1}};

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_CONFIRM = 2'd1,
    PH_HELD    = 2'd2,
    PH_RELWAIT = 2'd3
  } phase_e;

  typedef struct packed {
    logic [KEY_BITS-1:0] keys;
    logic                clear_pending;
  } in_item_t;

  typedef struct packed {
    logic                pending;
    logic [KEY_BITS-1:0] key_code;
    logic                long_press;
  } out_item_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] reset_code;
    logic [KEY_BITS-1:0] plus_code;
    logic [KEY_BITS-1:0] minus_code;
    logic [KEY_BITS-1:0] control_code;
    logic [THR_BITS-1:0] long_threshold;
  } cfg_t;

endpackage

// ----- rtl/kdlp_cfg.sv -----
module kdlp_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [kdlp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [kdlp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output kdlp_pkg::cfg_t                    cfg_o
);

  kdlp_pkg::cfg_t cfg_q;
  logic           wr_en;

  // Writes are always taken; indexes beyond the list are dropped
  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_code     <= kdlp_pkg::RESET_CODE_DEFAULT;
      cfg_q.plus_code      <= kdlp_pkg::PLUS_CODE_DEFAULT;
      cfg_q.minus_code     <= kdlp_pkg::MINUS_CODE_DEFAULT;
      cfg_q.control_code   <= kdlp_pkg::CONTROL_CODE_DEFAULT;
      cfg_q.long_threshold <= kdlp_pkg::LONG_THRESHOLD_DEFAULT;
    end else if (wr_en) begin
      case (cfg_index_i)
        kdlp_pkg::REG_RESET_CODE:
          cfg_q.reset_code <= cfg_data_i[kdlp_pkg::KEY_BITS-1:0];
        kdlp_pkg::REG_PLUS_CODE:
          cfg_q.plus_code <= cfg_data_i[kdlp_pkg::KEY_BITS-1:0];
        kdlp_pkg::REG_MINUS_CODE:
          cfg_q.minus_code <= cfg_data_i[kdlp_pkg::KEY_BITS-1:0];
        kdlp_pkg::REG_CONTROL_CODE:
          cfg_q.control_code <= cfg_data_i[kdlp_pkg::KEY_BITS-1:0];
        kdlp_pkg::REG_LONG_THRESHOLD:
          cfg_q.long_threshold <= cfg_data_i[kdlp_pkg::THR_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/kdlp_scan.sv -----
module kdlp_scan (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  kdlp_pkg::in_item_t   item_i,
  input  kdlp_pkg::cfg_t       cfg_i,
  output kdlp_pkg::out_item_t  result_o
);

  kdlp_pkg::phase_e                phase_q, phase_d;
  logic [kdlp_pkg::KEY_BITS-1:0]   cand_q, cand_d;
  logic [kdlp_pkg::HOLD_BITS-1:0]  hold_q, hold_d, hold_inc;
  logic [kdlp_pkg::KEY_BITS-1:0]   vcode_q, vcode_d;
  logic                            vlong_q, vlong_d;
  logic                            event_q, event_d;
  logic                            keys_zero, keys_same, cand_known;

  assign keys_zero  = (item_i.keys == '0);
  assign keys_same  = (cand_q == item_i.keys);
  assign cand_known = (cand_q == cfg_i.reset_code) || (cand_q == cfg_i.plus_code) ||
                      (cand_q == cfg_i.minus_code) || (cand_q == cfg_i.control_code);
  // Saturating hold counter
  assign hold_inc   = (hold_q == kdlp_pkg::HOLD_MAX) ? hold_q : hold_q + 1'b1;

  // Next state: clear strobe first, scan only while nothing is pending
  always_comb begin
    event_d = event_q & ~item_i.clear_pending;
    phase_d = phase_q;
    cand_d  = cand_q;
    hold_d  = hold_q;
    vcode_d = vcode_q;
    vlong_d = vlong_q;
    if (!event_d) begin
      case (phase_q)
        kdlp_pkg::PH_IDLE: begin
          hold_d = '0;
          cand_d = item_i.keys;
          if (!keys_zero) phase_d = kdlp_pkg::PH_CONFIRM;
        end
        kdlp_pkg::PH_CONFIRM: begin
          phase_d = keys_same ? kdlp_pkg::PH_HELD : kdlp_pkg::PH_IDLE;
        end
        kdlp_pkg::PH_HELD: begin
          if (keys_zero) begin
            // release: latch the pattern, raise only for a known code
            vcode_d = cand_q;
            vlong_d = 1'b0;
            phase_d = kdlp_pkg::PH_IDLE;
            event_d = cand_known;
          end else if (keys_same) begin
            hold_d = hold_inc;
            if (hold_inc > cfg_i.long_threshold) begin
              vcode_d = cand_q;
              vlong_d = 1'b0;
              if (cand_q == cfg_i.reset_code) begin
                vlong_d = 1'b1;
                event_d = 1'b1;
                phase_d = kdlp_pkg::PH_RELWAIT;
              end
            end
          end else begin
            phase_d = kdlp_pkg::PH_IDLE;
          end
        end
        kdlp_pkg::PH_RELWAIT: begin
          if (keys_zero) begin
            phase_d = kdlp_pkg::PH_IDLE;
            hold_d  = '0;
          end
        end
        default: phase_d = kdlp_pkg::PH_IDLE;
      endcase
    end
  end

  // State register, updated once per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= kdlp_pkg::PH_IDLE;
      cand_q  <= '0;
      hold_q  <= '0;
      vcode_q <= '0;
      vlong_q <= 1'b0;
      event_q <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cand_q  <= cand_d;
      hold_q  <= hold_d;
      vcode_q <= vcode_d;
      vlong_q <= vlong_d;
      event_q <= event_d;
    end
  end

  // Result reflects the state after this item
  assign result_o.pending    = event_d;
  assign result_o.key_code   = vcode_d;
  assign result_o.long_press = vlong_d;

endmodule

// ----- rtl/key_debounce_long_press.sv -----
// Key debouncer with long-press detection. Each input item is one scan tick
// (key vector plus a clear strobe for the pending event) and produces exactly
// one result item with the pending flag, the latched key code and the
// long-press flag as they stand after that tick. An item passes an input
// register, then the scan state update, and its result is held in a result
// register until it is taken. One item is taken every cycle while the output
// is not stalled; the state update between the two registers does not limit
// the rate. Configuration writes are always ready and take effect on the
// next item; write them only while no items are in flight.
module key_debounce_long_press (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  kdlp_pkg::in_item_t                in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output kdlp_pkg::out_item_t               out_item_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [kdlp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [kdlp_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  kdlp_pkg::cfg_t       cfg;
  kdlp_pkg::in_item_t   in_q;
  logic                 in_valid_q;
  kdlp_pkg::out_item_t  result;
  kdlp_pkg::out_item_t  out_q;
  logic                 out_valid_q;
  logic                 advance;

  kdlp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Item moves from the input register into the result register
  assign advance    = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & ~advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_item_i;
    end
  end

  kdlp_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ----- rtl/kdlp_checker.sv -----
module kdlp_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  kdlp_pkg::out_item_t  out_item_o
);

  // A stalled result stays in place
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result item changed or dropped");

  // Events are only raised for nonzero patterns
  a_pending_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.pending |-> out_item_o.key_code != '0)
    else $error("pending event with zero key code");

  // A long press always carries the held pattern
  a_long_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.long_press |-> out_item_o.key_code != '0)
    else $error("long press with zero key code");

endmodule

bind key_debounce_long_press kdlp_checker u_kdlp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

// ----- bench/key_debounce_long_press_tb.sv -----
`timescale 1ns / 100ps

module key_debounce_long_press_tb;

  localparam int CYCLE_LIMIT = 400000;
  // index past the register list, writes to it must be dropped
  localparam logic [kdlp_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  kdlp_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  kdlp_pkg::out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [kdlp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [kdlp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // stimulus and scoreboard
  kdlp_pkg::in_item_t scan_ticks_q[$];
  kdlp_pkg::out_item_t scan_results_q[$];
  kdlp_pkg::out_item_t next_result;
  int ticks_added = 0;
  int err_cnt = 0;
  int cycle_cnt = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // debouncer state as predicted
  kdlp_pkg::cfg_t key_cfg;
  kdlp_pkg::phase_e scan_phase;
  logic [kdlp_pkg::KEY_BITS-1:0] cand_keys;
  logic [kdlp_pkg::HOLD_BITS-1:0] hold_cnt;
  logic [kdlp_pkg::KEY_BITS-1:0] latched_code;
  logic latched_long;
  logic event_pending;

  key_debounce_long_press dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic logic code_known(input logic [kdlp_pkg::KEY_BITS-1:0] code);
    return code == key_cfg.reset_code || code == key_cfg.plus_code ||
           code == key_cfg.minus_code || code == key_cfg.control_code;
  endfunction

  // one scan tick of the debouncer; queues the result it produces
  task automatic debounce_tick(input kdlp_pkg::in_item_t tick);
    kdlp_pkg::out_item_t res;
    logic [kdlp_pkg::KEY_BITS-1:0] k;
    k = tick.keys;
    if (tick.clear_pending) event_pending = 1'b0;
    if (!event_pending) begin
      case (scan_phase)
        kdlp_pkg::PH_IDLE: begin
          hold_cnt = '0;
          cand_keys = k;
          if (k != '0) scan_phase = kdlp_pkg::PH_CONFIRM;
        end
        kdlp_pkg::PH_CONFIRM: begin
          scan_phase = (cand_keys == k) ? kdlp_pkg::PH_HELD : kdlp_pkg::PH_IDLE;
        end
        kdlp_pkg::PH_HELD: begin
          if (k == '0) begin
            latched_code = cand_keys;
            latched_long = 1'b0;
            scan_phase = kdlp_pkg::PH_IDLE;
            if (code_known(cand_keys)) event_pending = 1'b1;
          end else if (cand_keys == k) begin
            if (hold_cnt != kdlp_pkg::HOLD_MAX) hold_cnt = hold_cnt + 1'b1;
            if (hold_cnt > key_cfg.long_threshold) begin
              latched_code = cand_keys;
              latched_long = 1'b0;
              if (cand_keys == key_cfg.reset_code) begin
                latched_long = 1'b1;
                event_pending = 1'b1;
                scan_phase = kdlp_pkg::PH_RELWAIT;
              end
            end
          end else begin
            scan_phase = kdlp_pkg::PH_IDLE;
          end
        end
        default: begin
          if (k == '0) begin
            scan_phase = kdlp_pkg::PH_IDLE;
            hold_cnt = '0;
          end
        end
      endcase
    end
    res.pending = event_pending;
    res.key_code = latched_code;
    res.long_press = latched_long;
    scan_results_q.push_back(res);
  endtask

  task automatic flag_mismatch(input string what, input int want_v, input int got_v);
    err_cnt++;
    if (err_cnt <= 10)
      $display("mismatch at cycle %0d: %s expected %0d got %0d", cycle_cnt, what, want_v,
               got_v);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) debounce_tick(in_item);
      if (!in_valid || !in_stall) begin
        if (scan_ticks_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_item <= scan_ticks_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (scan_results_q.size() == 0) begin
          flag_mismatch("unexpected item, key_code", -1, out_item.key_code);
        end else begin
          next_result = scan_results_q.pop_front();
          if (out_item.pending !== next_result.pending)
            flag_mismatch("pending", next_result.pending, out_item.pending);
          if (out_item.key_code !== next_result.key_code)
            flag_mismatch("key_code", next_result.key_code, out_item.key_code);
          if (out_item.long_press !== next_result.long_press)
            flag_mismatch("long_press", next_result.long_press, out_item.long_press);
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [kdlp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [kdlp_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      kdlp_pkg::REG_RESET_CODE:
        key_cfg.reset_code = data[kdlp_pkg::KEY_BITS-1:0];
      kdlp_pkg::REG_PLUS_CODE:
        key_cfg.plus_code = data[kdlp_pkg::KEY_BITS-1:0];
      kdlp_pkg::REG_MINUS_CODE:
        key_cfg.minus_code = data[kdlp_pkg::KEY_BITS-1:0];
      kdlp_pkg::REG_CONTROL_CODE:
        key_cfg.control_code = data[kdlp_pkg::KEY_BITS-1:0];
      kdlp_pkg::REG_LONG_THRESHOLD:
        key_cfg.long_threshold = data;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (scan_ticks_q.size() != 0 || in_valid || scan_results_q.size() != 0)
      @(posedge clk);
  endtask

  // new key map and idling mix, applied only once the pipe is empty
  task automatic set_phase(input int idle_pct, input int stall_pct,
                           input logic [kdlp_pkg::KEY_BITS-1:0] rc,
                           input logic [kdlp_pkg::KEY_BITS-1:0] pc,
                           input logic [kdlp_pkg::KEY_BITS-1:0] mc,
                           input logic [kdlp_pkg::KEY_BITS-1:0] cc,
                           input logic [kdlp_pkg::THR_BITS-1:0] thr);
    logic [kdlp_pkg::CFG_DATA_W-1:0] d;
    wait_drained();
    // upper data bits are junk for the code registers
    d = $urandom;
    d[kdlp_pkg::KEY_BITS-1:0] = rc;
    write_reg(kdlp_pkg::REG_RESET_CODE, d);
    d = $urandom;
    d[kdlp_pkg::KEY_BITS-1:0] = pc;
    write_reg(kdlp_pkg::REG_PLUS_CODE, d);
    d = $urandom;
    d[kdlp_pkg::KEY_BITS-1:0] = mc;
    write_reg(kdlp_pkg::REG_MINUS_CODE, d);
    d = $urandom;
    d[kdlp_pkg::KEY_BITS-1:0] = cc;
    write_reg(kdlp_pkg::REG_CONTROL_CODE, d);
    write_reg(kdlp_pkg::REG_LONG_THRESHOLD, thr);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
  endtask

  task automatic push_tick(input logic [kdlp_pkg::KEY_BITS-1:0] k, input logic clr);
    kdlp_pkg::in_item_t tick;
    tick.keys = k;
    tick.clear_pending = clr;
    scan_ticks_q.push_back(tick);
    ticks_added++;
  endtask

  // press, confirm, hold for hold_ticks counted ticks, release
  task automatic add_press(input logic [kdlp_pkg::KEY_BITS-1:0] code, input int hold_ticks);
    push_tick(code, $urandom_range(0, 3) != 0);
    repeat (hold_ticks + 1) push_tick(code, $urandom_range(0, 7) == 0);
    push_tick('0, $urandom_range(0, 7) == 0);
  endtask

  function automatic logic [kdlp_pkg::KEY_BITS-1:0] pick_code();
    case ($urandom_range(0, 5))
      0: return key_cfg.reset_code;
      1: return key_cfg.plus_code;
      2: return key_cfg.minus_code;
      3: return key_cfg.control_code;
      default:
        return kdlp_pkg::KEY_BITS'($urandom_range(1, (1 << kdlp_pkg::KEY_BITS) - 1));
    endcase
  endfunction

  task automatic add_random(input int n);
    int stop;
    int kind;
    logic [kdlp_pkg::KEY_BITS-1:0] c;
    logic [kdlp_pkg::KEY_BITS-1:0] d;
    stop = ticks_added + n;
    while (ticks_added < stop) begin
      kind = $urandom_range(0, 99);
      c = pick_code();
      if (kind < 50) begin
        add_press(c, $urandom_range(0, 4));
      end else if (kind < 65) begin
        // long holds only where the threshold keeps them short
        if (key_cfg.long_threshold <= 8) begin
          if ($urandom_range(0, 1)) c = key_cfg.reset_code;
          add_press(c, key_cfg.long_threshold + $urandom_range(1, 3));
        end else begin
          add_press(key_cfg.reset_code, $urandom_range(0, 3));
        end
      end else if (kind < 80) begin
        // bounce: pattern changes partway through
        d = kdlp_pkg::KEY_BITS'($urandom_range(1, (1 << kdlp_pkg::KEY_BITS) - 1));
        push_tick(c, $urandom_range(0, 3) != 0);
        repeat ($urandom_range(0, 3)) push_tick(c, $urandom_range(0, 7) == 0);
        push_tick(d, $urandom_range(0, 7) == 0);
        push_tick('0, $urandom_range(0, 7) == 0);
      end else begin
        repeat ($urandom_range(1, 4))
          push_tick(kdlp_pkg::KEY_BITS'($urandom), $urandom_range(0, 1));
      end
    end
  endtask

  initial begin
    key_cfg.reset_code = kdlp_pkg::RESET_CODE_DEFAULT;
    key_cfg.plus_code = kdlp_pkg::PLUS_CODE_DEFAULT;
    key_cfg.minus_code = kdlp_pkg::MINUS_CODE_DEFAULT;
    key_cfg.control_code = kdlp_pkg::CONTROL_CODE_DEFAULT;
    key_cfg.long_threshold = kdlp_pkg::LONG_THRESHOLD_DEFAULT;
    scan_phase = kdlp_pkg::PH_IDLE;
    cand_keys = '0;
    hold_cnt = '0;
    latched_code = '0;
    latched_long = 1'b0;
    event_pending = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: default key map, short threshold
    set_phase(0, 0, 4'h1, 4'h2, 4'h4, 4'h8, 8'd2);
    push_tick(4'h0, 1'b0);
    push_tick(4'h2, 1'b1);
    push_tick(4'h2, 1'b0);
    push_tick(4'h0, 1'b0);
    // frozen while pending, then cleared
    push_tick(4'h4, 1'b0);
    push_tick(4'h0, 1'b1);
    // release of an unknown pattern
    push_tick(4'h3, 1'b0);
    push_tick(4'h3, 1'b0);
    push_tick(4'h0, 1'b0);
    // pattern changes while confirming
    push_tick(4'h5, 1'b0);
    push_tick(4'h6, 1'b0);
    push_tick(4'h0, 1'b0);
    // long press of the reset key, clear while still held
    repeat (5) push_tick(4'h1, 1'b0);
    push_tick(4'h1, 1'b1);
    push_tick(4'h0, 1'b0);
    // long hold of a key that is not the reset key
    repeat (5) push_tick(4'hF, 1'b0);
    push_tick(4'h0, 1'b0);
    // pattern changes while held
    push_tick(4'h8, 1'b0);
    push_tick(4'h8, 1'b0);
    push_tick(4'h9, 1'b0);
    push_tick(4'h0, 1'b0);
    add_random(180);

    set_phase(0, 0, 4'hF, 4'h0, 4'h7, 4'hA, 8'd0);
    write_reg(REG_SPARE, 8'hFF);
    add_random(180);

    set_phase(80, 0, 4'h3, 4'h3, 4'hC, 4'h5, 8'd5);
    add_random(180);

    set_phase(0, 80, 4'h0, 4'h1, 4'hE, 4'hF, 8'd1);
    add_random(180);

    // highest threshold that can still be exceeded
    set_phase(29, 29, 4'h6, 4'h9, 4'hF, 4'h1, 8'd254);
    push_tick(4'h0, 1'b1);
    add_press(4'h6, 255);
    push_tick(4'h0, 1'b1);
    add_press(4'h9, 258);
    add_random(100);

    // threshold that can never be exceeded; counter saturates
    set_phase(29, 29, 4'h2, 4'h4, 4'h8, 4'h2, 8'd255);
    push_tick(4'h0, 1'b1);
    add_press(4'h2, 258);
    add_random(100);

    wait_drained();
    repeat (10) @(posedge clk);
    if (err_cnt == 0 && scan_results_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
